@@ src/pitt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_pkg
// Shared types and fixed constants of the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
package pitt_pkg;

  // bit gained by a coordinate difference
  localparam int DIFF_EXT = 1;

  // bit gained by the difference of two products
  localparam int CROSS_EXT = 1;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } pitt_res_t;

endpackage

@@ src/pitt_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_in_if
// Input channel: triangle vertices a, b, c and query point p per beat.
// ----------------------------------------------------------------------------
interface pitt_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] p_x;
  logic signed [COORD_WIDTH-1:0] p_y;

  modport source (
    output valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y,
    input  ready
  );

  modport sink (
    input  valid, a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y,
    output ready
  );
endinterface

@@ src/pitt_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_out_if
// Result channel: inside flag and degenerate flag per beat.
// ----------------------------------------------------------------------------
interface pitt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (
    output valid, inside_res, degenerate,
    input  ready
  );

  modport sink (
    input  valid, inside_res, degenerate,
    output ready
  );
endinterface

@@ src/pitt_diff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_diff
// Stage 1: edge vectors ab, ac and offset ap relative to vertex a.
// ----------------------------------------------------------------------------
module pitt_diff
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  pitt_in_if.sink                                 in_bus,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ab_x_o,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ab_y_o,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ac_x_o,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ac_y_o,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ap_x_o,
  output logic signed [COORD_WIDTH+DIFF_EXT-1:0]  ap_y_o
);

  localparam int DW = COORD_WIDTH + DIFF_EXT;

  logic                 valid_r;
  logic                 adv;
  logic signed [DW-1:0] ab_x_r, ab_y_r, ac_x_r, ac_y_r, ap_x_r, ap_y_r;
  logic signed [DW-1:0] ab_x_nxt, ab_y_nxt, ac_x_nxt, ac_y_nxt, ap_x_nxt, ap_y_nxt;

  assign adv          = !valid_r || ready_i;
  assign in_bus.ready = adv;

  always_comb begin
    ab_x_nxt = DW'(in_bus.b_x) - DW'(in_bus.a_x);
    ab_y_nxt = DW'(in_bus.b_y) - DW'(in_bus.a_y);
    ac_x_nxt = DW'(in_bus.c_x) - DW'(in_bus.a_x);
    ac_y_nxt = DW'(in_bus.c_y) - DW'(in_bus.a_y);
    ap_x_nxt = DW'(in_bus.p_x) - DW'(in_bus.a_x);
    ap_y_nxt = DW'(in_bus.p_y) - DW'(in_bus.a_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_bus.valid) begin
      ab_x_r <= ab_x_nxt;
      ab_y_r <= ab_y_nxt;
      ac_x_r <= ac_x_nxt;
      ac_y_r <= ac_y_nxt;
      ap_x_r <= ap_x_nxt;
      ap_y_r <= ap_y_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ab_x_o  = ab_x_r;
  assign ab_y_o  = ab_y_r;
  assign ac_x_o  = ac_x_r;
  assign ac_y_o  = ac_y_r;
  assign ap_x_o  = ap_x_r;
  assign ap_y_o  = ap_y_r;

endmodule

@@ src/pitt_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_mul
// Stage 2: the six partial products of the three cross products.
// ----------------------------------------------------------------------------
module pitt_mul
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ab_x_i,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ab_y_i,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ac_x_i,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ac_y_i,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ap_x_i,
  input  logic signed [COORD_WIDTH+DIFF_EXT-1:0]      ap_y_i,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  d_pos_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  d_neg_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  u_pos_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  u_neg_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  v_pos_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]  v_neg_o
);

  localparam int DW = COORD_WIDTH + DIFF_EXT;
  localparam int PW = 2 * DW;

  logic                 valid_r;
  logic                 adv;
  logic signed [PW-1:0] d_pos_r, d_neg_r, u_pos_r, u_neg_r, v_pos_r, v_neg_r;
  logic signed [PW-1:0] d_pos_nxt, d_neg_nxt, u_pos_nxt, u_neg_nxt, v_pos_nxt, v_neg_nxt;

  assign adv     = !valid_r || ready_i;
  assign ready_o = adv;

  always_comb begin
    d_pos_nxt = PW'(ab_x_i) * PW'(ac_y_i);
    d_neg_nxt = PW'(ab_y_i) * PW'(ac_x_i);
    u_pos_nxt = PW'(ab_x_i) * PW'(ap_y_i);
    u_neg_nxt = PW'(ab_y_i) * PW'(ap_x_i);
    v_pos_nxt = PW'(ap_x_i) * PW'(ac_y_i);
    v_neg_nxt = PW'(ap_y_i) * PW'(ac_x_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      d_pos_r <= d_pos_nxt;
      d_neg_r <= d_neg_nxt;
      u_pos_r <= u_pos_nxt;
      u_neg_r <= u_neg_nxt;
      v_pos_r <= v_pos_nxt;
      v_neg_r <= v_neg_nxt;
    end
  end

  assign valid_o = valid_r;
  assign d_pos_o = d_pos_r;
  assign d_neg_o = d_neg_r;
  assign u_pos_o = u_pos_r;
  assign u_neg_o = u_neg_r;
  assign v_pos_o = v_pos_r;
  assign v_neg_o = v_neg_r;

endmodule

@@ src/pitt_cross.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_cross
// Stage 3: area term d = ab x ac and numerators nu = ab x ap, nv = ap x ac.
// ----------------------------------------------------------------------------
module pitt_cross
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           d_pos_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           d_neg_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           u_pos_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           u_neg_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           v_pos_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)-1:0]           v_neg_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] d_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] nu_o,
  output logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] nv_o
);

  localparam int PW = 2 * (COORD_WIDTH + DIFF_EXT);
  localparam int XW = PW + CROSS_EXT;

  logic                 valid_r;
  logic                 adv;
  logic signed [XW-1:0] d_r, nu_r, nv_r;
  logic signed [XW-1:0] d_nxt, nu_nxt, nv_nxt;

  assign adv     = !valid_r || ready_i;
  assign ready_o = adv;

  always_comb begin
    d_nxt  = XW'(d_pos_i) - XW'(d_neg_i);
    nu_nxt = XW'(u_pos_i) - XW'(u_neg_i);
    nv_nxt = XW'(v_pos_i) - XW'(v_neg_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_i) begin
      d_r  <= d_nxt;
      nu_r <= nu_nxt;
      nv_r <= nv_nxt;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;
  assign nu_o    = nu_r;
  assign nv_o    = nv_r;

endmodule

@@ src/pitt_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitt_decide
// Stages 4 and 5: orient the triangle so d >= 0, then check nu >= 0, nv >= 0
// and nu + nv <= d; the second stage is the result register.
// ----------------------------------------------------------------------------
module pitt_decide
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] d_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] nu_i,
  input  logic signed [2*(COORD_WIDTH+DIFF_EXT)+CROSS_EXT-1:0] nv_i,
  pitt_out_if.source                                           out_bus
);

  localparam int XW = 2 * (COORD_WIDTH + DIFF_EXT) + CROSS_EXT;
  localparam int SW = XW + 2;

  // orientation stage
  logic                 o_valid_r;
  logic                 o_adv;
  logic                 o_degen_r, o_degen_nxt;
  logic signed [XW-1:0] o_d_r, o_nu_r, o_nv_r;
  logic signed [XW-1:0] o_d_nxt, o_nu_nxt, o_nv_nxt;

  // result stage
  logic                 r_valid_r;
  logic                 r_adv;
  pitt_res_t            res_r, res_nxt;
  logic signed [SW-1:0] slack;

  assign r_adv   = !r_valid_r || out_bus.ready;
  assign o_adv   = !o_valid_r || r_adv;
  assign ready_o = o_adv;

  always_comb begin
    o_degen_nxt = (d_i == '0);
    if (d_i[XW-1]) begin
      o_d_nxt  = -d_i;
      o_nu_nxt = -nu_i;
      o_nv_nxt = -nv_i;
    end else begin
      o_d_nxt  = d_i;
      o_nu_nxt = nu_i;
      o_nv_nxt = nv_i;
    end
  end

  always_comb begin
    slack              = SW'(o_d_r) - SW'(o_nu_r) - SW'(o_nv_r);
    res_nxt.degenerate = o_degen_r;
    res_nxt.inside_res = !o_degen_r && !o_nu_r[XW-1] && !o_nv_r[XW-1] && !slack[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
    end else begin
      if (o_adv) begin
        o_valid_r <= valid_i;
      end
      if (r_adv) begin
        r_valid_r <= o_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && valid_i) begin
      o_degen_r <= o_degen_nxt;
      o_d_r     <= o_d_nxt;
      o_nu_r    <= o_nu_nxt;
      o_nv_r    <= o_nv_nxt;
    end
    if (r_adv && o_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid      = r_valid_r;
  assign out_bus.inside_res = res_r.inside_res;
  assign out_bus.degenerate = res_r.degenerate;

endmodule

@@ src/point_in_triangle_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Barycentric point-in-triangle test over a five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one triangle/point beat per clock while the output is not stalled
// and returns one result beat per input beat, in order. The stages are:
// edge differences, six signed multiplies, cross product subtracts,
// orientation, and the final compare into the result register. Every stage
// holds its own valid bit, so a stall on the output fills bubbles before it
// pushes back on the input. Points on an edge or vertex count as inside; a
// zero-area triangle sets degenerate and clears inside_res.
// ----------------------------------------------------------------------------
module point_in_triangle_test
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pitt_in_if.sink    in_bus,
  pitt_out_if.source out_bus
);

  localparam int DW = COORD_WIDTH + DIFF_EXT;
  localparam int PW = 2 * DW;
  localparam int XW = PW + CROSS_EXT;

  logic                 s1_valid, s1_ready;
  logic signed [DW-1:0] ab_x, ab_y, ac_x, ac_y, ap_x, ap_y;

  logic                 s2_valid, s2_ready;
  logic signed [PW-1:0] d_pos, d_neg, u_pos, u_neg, v_pos, v_neg;

  logic                 s3_valid, s3_ready;
  logic signed [XW-1:0] d, nu, nv;

  pitt_diff #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .ab_x_o  (ab_x),
    .ab_y_o  (ab_y),
    .ac_x_o  (ac_x),
    .ac_y_o  (ac_y),
    .ap_x_o  (ap_x),
    .ap_y_o  (ap_y)
  );

  pitt_mul #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .ab_x_i  (ab_x),
    .ab_y_i  (ab_y),
    .ac_x_i  (ac_x),
    .ac_y_i  (ac_y),
    .ap_x_i  (ap_x),
    .ap_y_i  (ap_y),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .d_pos_o (d_pos),
    .d_neg_o (d_neg),
    .u_pos_o (u_pos),
    .u_neg_o (u_neg),
    .v_pos_o (v_pos),
    .v_neg_o (v_neg)
  );

  pitt_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .d_pos_i (d_pos),
    .d_neg_i (d_neg),
    .u_pos_i (u_pos),
    .u_neg_i (u_neg),
    .v_pos_i (v_pos),
    .v_neg_i (v_neg),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .d_o     (d),
    .nu_o    (nu),
    .nv_o    (nv)
  );

  pitt_decide #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .d_i     (d),
    .nu_i    (nu),
    .nv_i    (nv),
    .out_bus (out_bus)
  );

endmodule
